>>> hw/rtl/bid_pkg.sv
package bid_pkg;

    localparam int FRAC_W    = 17;
    localparam int DEPTH_W   = 5;
    localparam int FPC_W     = 25;
    localparam int DUR_W     = 48;
    localparam int PIX_W     = 16;
    localparam int THR_W     = 16;
    localparam int PROD_W    = FRAC_W + FPC_W;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;
    localparam int REG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [REG_IDX_W-1:0] REG_PIX_FRAC  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BIT_DEPTH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FULL_RNG  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PIC_RATIO = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_PIX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DUR   = 3'd5;

    localparam logic [FRAC_W-1:0]  RST_PIX_FRAC  = 17'd6554;
    localparam logic [DEPTH_W-1:0] RST_BIT_DEPTH = 5'd8;
    localparam logic               RST_FULL_RNG  = 1'b0;
    localparam logic [FRAC_W-1:0]  RST_PIC_RATIO = 17'd64225;
    localparam logic [FPC_W-1:0]   RST_FRAME_PIX = 25'd2073600;
    localparam logic [DUR_W-1:0]   RST_MIN_DUR   = 48'd180000;

    localparam logic [FRAC_W-1:0]  Q16_ONE   = 17'd65536;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 5'd8;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd16;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } t_event;

    typedef struct packed {
        logic [THR_W-1:0]  thr;
        logic [PIX_W-1:0]  mask;
        logic [PROD_W-1:0] ratio_prod;
        logic [DUR_W-1:0]  min_dur;
    } t_cfg;

    function automatic logic [DEPTH_W-1:0] f_eff_depth(input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0] d;
        d = depth;
        if (depth < DEPTH_MIN) begin
            d = DEPTH_MIN;
        end else if (depth > DEPTH_MAX) begin
            d = DEPTH_MAX;
        end
        return d;
    endfunction

    function automatic logic [FRAC_W-1:0] f_clamp_q16(input logic [FRAC_W-1:0] v);
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

    function automatic logic [PIX_W-1:0] f_depth_mask(input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0] d;
        d = f_eff_depth(depth);
        return PIX_W'((17'd1 << d) - 17'd1);
    endfunction

    function automatic logic [THR_W-1:0] f_pix_threshold(
        input logic [FRAC_W-1:0]  frac,
        input logic [DEPTH_W-1:0] depth,
        input logic               full
    );
        logic [FRAC_W-1:0]  f;
        logic [DEPTH_W-1:0] d;
        logic [3:0]         sh;
        logic [PIX_W-1:0]   maxv;
        logic [32:0]        pf;
        logic [32:0]        pl;
        logic [16:0]        base;
        logic [THR_W-1:0]   res;
        f    = f_clamp_q16(frac);
        d    = f_eff_depth(depth);
        sh   = 4'(d - DEPTH_MIN);
        maxv = PIX_W'((17'd1 << d) - 17'd1);
        pf   = 33'(f) * 33'(maxv);
        pl   = 33'(f * 25'd219) << sh;
        base = 17'd16 << sh;
        if (full) begin
            res = THR_W'(pf >> 16);
        end else begin
            res = THR_W'(base + pl[32:16]);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/bid_if.sv
interface bid_in_if #(
    parameter int TIME_W = 48
);
    logic              valid;
    logic              ready;
    logic              func;
    logic [15:0]       pixel_value;
    logic              last_in_frame;
    logic [TIME_W-1:0] frame_time;

    modport source (output valid, func, pixel_value, last_in_frame, frame_time, input ready);
    modport sink   (input valid, func, pixel_value, last_in_frame, frame_time, output ready);
endinterface

interface bid_out_if #(
    parameter int CNT_W  = 25,
    parameter int TIME_W = 48
);
    logic              valid;
    logic              ready;
    logic [1:0]        event_res;
    logic              frame_black;
    logic [CNT_W-1:0]  black_pixel_count;
    logic [TIME_W-1:0] run_start_time;
    logic [TIME_W-1:0] run_end_time;
    logic [TIME_W-1:0] run_length;
    logic              duration_met;

    modport source (output valid, event_res, frame_black, black_pixel_count, run_start_time,
                    run_end_time, run_length, duration_met, input ready);
    modport sink   (input valid, event_res, frame_black, black_pixel_count, run_start_time,
                    run_end_time, run_length, duration_met, output ready);
endinterface

>>> hw/rtl/black_interval_detector_core.sv
// Black interval detector.
// Luma samples enter on i_pix, one transfer per sample; last_in_frame marks the
// final sample of a frame and func set to one marks the end of the stream.
// One result leaves on o_res for every finished frame, and one for an end of
// stream that closes an open black run; other transfers give no result.
// The APB port holds the thresholds, frame size and minimum run length; the user
// is to write it only while the block is idle, which the block does not enforce;
// pready is always high. A sample is taken every cycle while the queue has room.
// The front counts black samples and passes each frame end into a four-entry
// queue; the back compares the count with the ratio, tracks the run and loads
// the output register. A frame end reaches o_res via its queue entry and that register.
// If o_res stalls, the queue fills and i_pix.ready falls once it holds four
// frame ends; samples within a frame never wait on the queue until then.
// Reset, synchronous and active low, loads the register defaults, clears the
// black count and closes any run; derived thresholds are ready on the first
// cycle after reset.
module black_interval_detector_core
    import bid_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = 16777216,
    parameter int TIME_BITS        = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    bid_in_if.sink            i_pix,
    bid_out_if.source         o_res
);

    localparam int CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int ITEM_W = 1 + CNT_W + TIME_BITS;

    t_cfg              cfg;
    logic              q_full;
    logic              q_push;
    logic [ITEM_W-1:0] q_wdata;
    logic              q_pop;
    logic              q_vld;
    logic [ITEM_W-1:0] q_rdata;

    bid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bid_front #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
        .TIME_BITS        (TIME_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    bid_queue #(
        .W     (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_rdata)
    );

    bid_back #(
        .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
        .TIME_BITS        (TIME_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_vld  (q_vld),
        .i_q_data (q_rdata),
        .o_q_pop  (q_pop),
        .o_res    (o_res)
    );

endmodule

>>> hw/rtl/bid_cfg.sv
module bid_cfg
    import bid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [FRAC_W-1:0]    r_frac, n_frac;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic                 r_full, n_full;
    logic [FRAC_W-1:0]    r_ratio, n_ratio;
    logic [FPC_W-1:0]     r_fpc, n_fpc;
    logic [DUR_W-1:0]     r_min, n_min;
    logic [THR_W-1:0]     r_thr;
    logic [PIX_W-1:0]     r_mask;
    logic [PROD_W-1:0]    r_prod;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[APB_AW-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_frac  = r_frac;
        n_depth = r_depth;
        n_full  = r_full;
        n_ratio = r_ratio;
        n_fpc   = r_fpc;
        n_min   = r_min;
        if (!i_rst_n) begin
            n_frac  = RST_PIX_FRAC;
            n_depth = RST_BIT_DEPTH;
            n_full  = RST_FULL_RNG;
            n_ratio = RST_PIC_RATIO;
            n_fpc   = RST_FRAME_PIX;
            n_min   = RST_MIN_DUR;
        end else if (wr) begin
            case (idx)
                REG_PIX_FRAC:  n_frac  = pwdata[FRAC_W-1:0];
                REG_BIT_DEPTH: n_depth = pwdata[DEPTH_W-1:0];
                REG_FULL_RNG:  n_full  = pwdata[0];
                REG_PIC_RATIO: n_ratio = pwdata[FRAC_W-1:0];
                REG_FRAME_PIX: n_fpc   = pwdata[FPC_W-1:0];
                REG_MIN_DUR:   n_min   = pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac  <= RST_PIX_FRAC;
            r_depth <= RST_BIT_DEPTH;
            r_full  <= RST_FULL_RNG;
            r_ratio <= RST_PIC_RATIO;
            r_fpc   <= RST_FRAME_PIX;
            r_min   <= RST_MIN_DUR;
        end else begin
            r_frac  <= n_frac;
            r_depth <= n_depth;
            r_full  <= n_full;
            r_ratio <= n_ratio;
            r_fpc   <= n_fpc;
            r_min   <= n_min;
        end
    end

    // Derived values follow the next register contents, so they are valid straight after reset.
    always_ff @(posedge i_clk) begin
        r_thr  <= f_pix_threshold(n_frac, n_depth, n_full);
        r_mask <= f_depth_mask(n_depth);
        r_prod <= PROD_W'(f_clamp_q16(n_ratio)) * PROD_W'(n_fpc);
    end

    always_comb begin
        case (idx)
            REG_PIX_FRAC:  prdata = APB_DW'(r_frac);
            REG_BIT_DEPTH: prdata = APB_DW'(r_depth);
            REG_FULL_RNG:  prdata = APB_DW'(r_full);
            REG_PIC_RATIO: prdata = APB_DW'(r_ratio);
            REG_FRAME_PIX: prdata = APB_DW'(r_fpc);
            REG_MIN_DUR:   prdata = APB_DW'(r_min);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.thr        = r_thr;
    assign o_cfg.mask       = r_mask;
    assign o_cfg.ratio_prod = r_prod;
    assign o_cfg.min_dur    = r_min;

endmodule

>>> hw/rtl/bid_front.sv
module bid_front
    import bid_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = 16777216,
    parameter int TIME_BITS        = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bid_in_if.sink         i_pix,
    input  t_cfg           i_cfg,
    input  logic           i_q_full,
    output logic           o_q_push,
    output logic [$clog2(MAX_FRAME_PIXELS+1)+TIME_BITS:0] o_q_data
);

    localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic [PIX_W-1:0] pix_m;
    logic             acc;
    logic             inc;
    logic             frame_end;

    assign i_pix.ready = !i_q_full;
    assign acc         = i_pix.valid && !i_q_full;
    assign pix_m       = i_pix.pixel_value & i_cfg.mask;
    assign inc         = (pix_m <= i_cfg.thr) && (r_cnt < CNT_W'(MAX_FRAME_PIXELS));
    assign cnt_inc     = r_cnt + CNT_W'(inc);
    assign frame_end   = i_pix.func || i_pix.last_in_frame;
    assign o_q_push    = acc && frame_end;

    always_comb begin
        if (i_pix.func) begin
            o_q_data = {1'b1, {(CNT_W + TIME_BITS){1'b0}}};
        end else begin
            o_q_data = {1'b0, cnt_inc, i_pix.frame_time};
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (acc) begin
            n_cnt = frame_end ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hw/rtl/bid_queue.sv
module bid_queue #(
    parameter int W     = 74,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_vld,
    output logic [W-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

>>> hw/rtl/bid_back.sv
module bid_back
    import bid_pkg::*;
#(
    parameter int MAX_FRAME_PIXELS = 16777216,
    parameter int TIME_BITS        = 48
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_q_vld,
    input  logic [$clog2(MAX_FRAME_PIXELS+1)+TIME_BITS:0] i_q_data,
    output logic     o_q_pop,
    bid_out_if.source o_res
);

    localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int CMP_W = (CNT_W + 16 > PROD_W) ? CNT_W + 16 : PROD_W;
    localparam int LEN_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

    logic                 q_eos;
    logic [CNT_W-1:0]     q_cnt;
    logic [TIME_BITS-1:0] q_time;
    logic                 black;
    logic [TIME_BITS-1:0] end_t;
    logic                 end_ge;
    logic [TIME_BITS-1:0] len;
    logic                 met;

    logic                 r_run_active, n_run_active;
    logic [TIME_BITS-1:0] r_run_start, n_run_start;
    logic [TIME_BITS-1:0] r_prev, n_prev;
    logic                 r_out_vld, n_out_vld;
    t_event               r_event, n_event;
    logic                 r_fb, n_fb;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [TIME_BITS-1:0] r_st, n_st;
    logic [TIME_BITS-1:0] r_et, n_et;
    logic [TIME_BITS-1:0] r_len, n_len;
    logic                 r_met, n_met;

    assign q_eos  = i_q_data[CNT_W + TIME_BITS];
    assign q_cnt  = i_q_data[TIME_BITS +: CNT_W];
    assign q_time = i_q_data[TIME_BITS-1:0];

    assign black  = CMP_W'({q_cnt, 16'h0000}) >= CMP_W'(i_cfg.ratio_prod);
    assign end_t  = q_eos ? r_prev : q_time;
    assign end_ge = end_t >= r_run_start;
    assign len    = end_ge ? end_t - r_run_start : '0;
    assign met    = end_ge && (LEN_W'(len) >= LEN_W'(i_cfg.min_dur));

    assign o_q_pop = i_q_vld && (!r_out_vld || o_res.ready);

    always_comb begin
        n_run_active = r_run_active;
        n_run_start  = r_run_start;
        n_prev       = r_prev;
        n_out_vld    = r_out_vld && !o_res.ready;
        n_event      = r_event;
        n_fb         = r_fb;
        n_cnt        = r_cnt;
        n_st         = r_st;
        n_et         = r_et;
        n_len        = r_len;
        n_met        = r_met;
        if (o_q_pop) begin
            n_event = EV_NONE;
            n_fb    = 1'b0;
            n_cnt   = '0;
            n_st    = '0;
            n_et    = '0;
            n_len   = '0;
            n_met   = 1'b0;
            if (q_eos) begin
                if (r_run_active) begin
                    n_out_vld    = 1'b1;
                    n_run_active = 1'b0;
                    n_event      = EV_END;
                    n_st         = r_run_start;
                    n_et         = end_t;
                    n_len        = len;
                    n_met        = met;
                end
            end else begin
                n_out_vld = 1'b1;
                n_fb      = black;
                n_cnt     = q_cnt;
                n_prev    = q_time;
                if (black) begin
                    if (!r_run_active) begin
                        n_run_active = 1'b1;
                        n_run_start  = q_time;
                        n_event      = EV_START;
                        n_st         = q_time;
                    end else begin
                        n_st = r_run_start;
                    end
                end else if (r_run_active) begin
                    n_run_active = 1'b0;
                    n_event      = EV_END;
                    n_st         = r_run_start;
                    n_et         = end_t;
                    n_len        = len;
                    n_met        = met;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_active <= 1'b0;
            r_run_start  <= '0;
            r_prev       <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_run_active <= n_run_active;
            r_run_start  <= n_run_start;
            r_prev       <= n_prev;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_event <= n_event;
        r_fb    <= n_fb;
        r_cnt   <= n_cnt;
        r_st    <= n_st;
        r_et    <= n_et;
        r_len   <= n_len;
        r_met   <= n_met;
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.event_res         = r_event;
    assign o_res.frame_black       = r_fb;
    assign o_res.black_pixel_count = r_cnt;
    assign o_res.run_start_time    = r_st;
    assign o_res.run_end_time      = r_et;
    assign o_res.run_length        = r_len;
    assign o_res.duration_met      = r_met;

`ifndef NO_ASSERTIONS
    a_start_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_event == EV_START) |-> r_fb && r_run_active)
        else $error("Run start reported for a frame that is not black.");

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_event == EV_END) |-> !r_fb && !r_run_active)
        else $error("Run end reported while the run is still open.");

    a_none_tracks_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_event == EV_NONE) |-> (r_fb == r_run_active))
        else $error("Frame result disagrees with the run state.");

    a_end_fields_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_event != EV_END) |-> (r_et == '0) && (r_len == '0) && !r_met)
        else $error("End fields set on a result that ends no run.");
`endif

endmodule
